>>> design/gnms_pkg.sv
// Shared constants, codes and types for the gradient NMS edge thinner.
// No dependencies; imported by gradient_nms_edge_thinner.
package gnms_pkg;

  // Line store geometry
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int CNT_W     = COL_W + 1;
  localparam int CFG_W_W   = 11;
  localparam int WID_W     = (CNT_W > CFG_W_W) ? CNT_W : CFG_W_W;

  // Field and register widths
  localparam int MAG_W   = 8;
  localparam int ROW_W   = 10;
  localparam int THR_W   = 8;
  localparam int IDX_W   = 2;
  localparam int SC_W    = 6;
  localparam int SLOPE_W = 20;

  // Register limits and reset values
  localparam int WIDTH_MIN    = 64;
  localparam int HEIGHT_MIN   = 3;
  localparam int HEIGHT_MAX   = 1023;
  localparam int WIDTH_RST    = 640;
  localparam int HEIGHT_RST   = 180;
  localparam int THRESH_RST   = 200;

  // Direction slopes in Q10: tan(22.5) and tan(67.5) scaled by 1024
  localparam int SLOPE_LO = 424;
  localparam int SLOPE_HI = 2472;

  // Fixed magnitude floor and run suppression shape
  localparam int MAG_FLOOR  = 30;
  localparam int RUN_LEN    = 50;
  localparam int RUN_PASS   = 4;
  localparam int RUN_HOLD   = RUN_LEN + 1 - RUN_PASS;
  localparam int RUN_MARGIN = 10;

  typedef enum logic [1:0] {
    DIR_HORZ = 2'd0,
    DIR_DIAG = 2'd1,
    DIR_VERT = 2'd2,
    DIR_NONE = 2'd3
  } dir_t;

  typedef enum logic [IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_THRESH = 2'd2
  } cfg_reg_t;

  // One line store word: direction, upper row and center row magnitude
  typedef struct packed {
    dir_t             dir;
    logic [MAG_W-1:0] upper;
    logic [MAG_W-1:0] center;
  } line_word_t;

  // Work stage: the pixel plus forwarding from the pixel ahead of it
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [MAG_W-1:0] mag;
    dir_t             dir;
    logic             fw0;
    logic             fw1;
    logic [MAG_W-1:0] f_center;
    logic [MAG_W-1:0] f_upper;
    dir_t             f_dir;
  } stage_t;

endpackage

>>> design/gnms_ram.sv
// Generic single-write, dual-read RAM with registered, enabled read.
// No dependencies.
module gnms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old word on a same-cycle write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> design/gradient_nms_edge_thinner.sv
// Top level of the gradient NMS edge thinner: counters, line store, decision, output.
// Depends on gnms_pkg and gnms_ram.
//
//  channel | beat signals              | payload
//  --------+---------------------------+----------------------------------------
//  in      | in_valid / in_ready       | grad_x_abs, grad_y_abs, frame_start
//  out     | out_valid / out_ready     | edge_res, row_end, frame_end
//  cfg     | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
// One pixel per clock unless the output stalls. Path of a result after its pixel's beat:
// line store read on accept, decision in the work stage, then the output register.
// Pixels of input row 0 give no result and leave the work stage without waiting.
// rst clears counters, run state, stage valid and output valid and holds both
// ready outputs low; line store is not cleared.
// A stalled output holds the work stage; a free stage takes a beat.
module gradient_nms_edge_thinner
  import gnms_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [MAG_W-1:0]     grad_x_abs,
  input  logic [MAG_W-1:0]     grad_y_abs,
  input  logic                 frame_start,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 edge_res,
  output logic                 row_end,
  output logic                 frame_end,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [IDX_W-1:0]     cfg_index,
  input  logic [CFG_W_W-1:0]   cfg_data
);

  // Configuration registers
  logic [CFG_W_W-1:0] image_width;
  logic [ROW_W-1:0]   image_height;
  logic [THR_W-1:0]   edge_threshold;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= CFG_W_W'(WIDTH_RST);
      image_height   <= ROW_W'(HEIGHT_RST);
      edge_threshold <= THR_W'(THRESH_RST);
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIDTH:  image_width    <= cfg_data;
        REG_HEIGHT: image_height   <= cfg_data[ROW_W-1:0];
        REG_THRESH: edge_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry after clamping
  logic [WID_W-1:0] width_ext;
  logic [CNT_W-1:0] w;
  logic [CNT_W-1:0] w_last;
  logic [ROW_W-1:0] h;

  always_comb begin
    width_ext = WID_W'(image_width);
    if (width_ext < WID_W'(WIDTH_MIN)) width_ext = WID_W'(WIDTH_MIN);
    else if (width_ext > WID_W'(MAX_WIDTH)) width_ext = WID_W'(MAX_WIDTH);
    w = width_ext[CNT_W-1:0];
    h = image_height;
    if (h < ROW_W'(HEIGHT_MIN)) h = ROW_W'(HEIGHT_MIN);
  end
  assign w_last = w - 1'b1;

  // Handshake control
  stage_t           s1;
  logic             s1_valid;
  logic             s1_adv;
  logic             s1_has_out;
  logic             in_beat;

  assign s1_has_out = (s1.row != '0);
  assign s1_adv     = s1_valid && (!s1_has_out || !out_valid || out_ready);
  assign in_ready   = !rst && (!s1_valid || s1_adv);
  assign in_beat    = in_valid && in_ready;

  // Position of the incoming pixel
  logic [COL_W-1:0] col_cnt_lo;
  logic [CNT_W-1:0] col_cnt;
  logic [ROW_W-1:0] row_cnt;
  logic [CNT_W-1:0] col_t;
  logic [ROW_W:0]   row_t;
  logic [COL_W-1:0] j_new;
  logic [COL_W-1:0] j_nb;
  logic [ROW_W-1:0] r_new;

  always_comb begin
    col_t = frame_start ? '0 : col_cnt;
    row_t = frame_start ? '0 : {1'b0, row_cnt};
    if (col_t >= w) begin
      col_t = '0;
      row_t = row_t + 1'b1;
    end
    if (row_t > {1'b0, h}) row_t = '0;
  end

  assign j_new      = col_t[COL_W-1:0];
  assign j_nb       = j_new + 1'b1;
  assign r_new      = row_t[ROW_W-1:0];
  assign col_cnt_lo = col_cnt[COL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (in_beat) begin
      col_cnt <= {1'b0, j_new} + 1'b1;
      row_cnt <= r_new;
    end
  end

  // Magnitude and direction of the incoming pixel
  logic [MAG_W+1:0]   mag_sum;
  logic [MAG_W-1:0]   mag_new;
  dir_t               dir_new;
  logic [SLOPE_W-1:0] gy_q10;
  logic [SLOPE_W-1:0] lim_lo;
  logic [SLOPE_W-1:0] lim_hi;

  assign mag_sum = {1'b0, grad_x_abs, 1'b0} + {1'b0, grad_y_abs, 1'b0};
  assign gy_q10  = SLOPE_W'({grad_y_abs, 10'b0});
  assign lim_lo  = SLOPE_W'(grad_x_abs) * SLOPE_W'(SLOPE_LO);
  assign lim_hi  = SLOPE_W'(grad_x_abs) * SLOPE_W'(SLOPE_HI);

  always_comb begin
    mag_new = '0;
    dir_new = DIR_NONE;
    if (r_new < h) begin
      mag_new = (mag_sum > (MAG_W+2)'(255)) ? '1 : mag_sum[MAG_W-1:0];
      if (grad_x_abs != '0) begin
        priority if (gy_q10 < lim_lo) dir_new = DIR_HORZ;
        else if (gy_q10 < lim_hi)     dir_new = DIR_DIAG;
        else                          dir_new = DIR_VERT;
      end
    end
  end

  // Line store: read at j and j+1 on the beat, written from the work stage
  line_word_t rd_a;
  line_word_t rd_b;
  line_word_t wr_word;

  gnms_ram #(
    .WIDTH ($bits(line_word_t)),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk     (clk),
    .we      (s1_adv),
    .waddr   (s1.col),
    .wdata   (wr_word),
    .re      (in_beat),
    .raddr_a (j_new),
    .raddr_b (j_nb),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // Work stage window, with the write of the pixel ahead forwarded
  logic [MAG_W-1:0] c0;
  logic [MAG_W-1:0] u0;
  dir_t             d0;
  logic [MAG_W-1:0] c1;
  logic [MAG_W-1:0] u1;

  assign c0 = s1.fw0 ? s1.f_center : rd_a.center;
  assign u0 = s1.fw0 ? s1.f_upper  : rd_a.upper;
  assign d0 = s1.fw0 ? s1.f_dir    : rd_a.dir;
  assign c1 = s1.fw1 ? s1.f_center : rd_b.center;
  assign u1 = s1.fw1 ? s1.f_upper  : rd_b.upper;

  assign wr_word = '{dir: s1.dir, upper: c0, center: s1.mag};

  // Stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1.row      <= r_new;
      s1.col      <= j_new;
      s1.mag      <= mag_new;
      s1.dir      <= dir_new;
      s1.fw0      <= s1_adv && (s1.col == j_new);
      s1.fw1      <= s1_adv && (s1.col == j_nb);
      s1.f_center <= s1.mag;
      s1.f_upper  <= c0;
      s1.f_dir    <= s1.dir;
    end
  end

  // Previous column magnitudes
  logic [MAG_W-1:0] prev_upper;
  logic [MAG_W-1:0] prev_center;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_upper  <= '0;
      prev_center <= '0;
    end else if (s1_adv) begin
      prev_upper  <= u0;
      prev_center <= c0;
    end
  end

  // Non-maximum decision and run suppression
  logic [CNT_W-1:0] j_ext;
  logic             has_right;
  logic [MAG_W-1:0] cl;
  logic [MAG_W-1:0] cr;
  logic [MAG_W-1:0] ul;
  logic [MAG_W-1:0] ur;
  logic [MAG_W-1:0] nb_a;
  logic [MAG_W-1:0] nb_b;
  logic             is_max;
  logic             edge_bit;
  logic [SC_W-1:0]  sc;
  logic [SC_W-1:0]  sc_base;
  logic [SC_W-1:0]  sc_next;
  logic             in_run_rows;

  assign j_ext     = {1'b0, s1.col};
  assign has_right = (j_ext + 1'b1) < w;
  assign cl        = (s1.col != '0) ? prev_center : '0;
  assign ul        = (s1.col != '0) ? prev_upper  : '0;
  assign cr        = has_right ? c1 : '0;
  assign ur        = has_right ? u1 : '0;
  assign in_run_rows = (s1.row >= ROW_W'(2)) && (s1.row < h);

  always_comb begin
    unique case (d0)
      DIR_HORZ: begin nb_a = cl;   nb_b = cr;     end
      DIR_DIAG: begin nb_a = ur;   nb_b = ul;     end
      DIR_VERT: begin nb_a = u0;   nb_b = s1.mag; end
      default:  begin nb_a = '0;   nb_b = '0;     end
    endcase
    is_max = (c0 >= nb_a) && (c0 >= nb_b);

    edge_bit = 1'b0;
    if (s1.row != ROW_W'(1) && s1.col != '0 && d0 != DIR_NONE &&
        c0 > MAG_W'(MAG_FLOOR) && c0 > edge_threshold) begin
      edge_bit = is_max;
    end

    sc_base = (s1.col == '0) ? '0 : sc;
    sc_next = sc_base;
    if (in_run_rows) begin
      if (sc_base != '0) begin
        if (sc_base <= SC_W'(RUN_HOLD)) edge_bit = 1'b0;
        sc_next = sc_base - 1'b1;
      end else if (edge_bit && s1.col != '0 && (j_ext + CNT_W'(RUN_MARGIN)) < w) begin
        if ((j_ext + CNT_W'(RUN_LEN)) >= w) edge_bit = 1'b0;
        sc_next = SC_W'(RUN_LEN);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sc <= '0;
    end else if (s1_adv && s1_has_out) begin
      sc <= sc_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_has_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_has_out) begin
      edge_res  <= edge_bit;
      row_end   <= (j_ext == w_last);
      frame_end <= (s1.row == h) && (j_ext == w_last);
    end
  end

  // Checks
  a_fwd_excl: assert property (@(posedge clk) disable iff (rst)
    s1_valid |-> !(s1.fw0 && s1.fw1))
    else $error("forwarding hits both window columns");

  a_run_len: assert property (@(posedge clk) disable iff (rst)
    sc <= SC_W'(RUN_LEN))
    else $error("run counter beyond run length");

  a_beat_fill: assert property (@(posedge clk) disable iff (rst)
    in_beat |=> s1_valid)
    else $error("accepted pixel missing from work stage");

  a_frame_row: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> row_end)
    else $error("frame end without row end");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col_cnt <= CNT_W'(MAX_WIDTH))
    else $error("column counter out of range");

  // keeps the low column bits in view for the wrap check below
  a_col_wrap: assert property (@(posedge clk) disable iff (rst)
    (in_beat && !frame_start && col_cnt < w) |-> (j_new == col_cnt_lo))
    else $error("column advanced without wrap cause");

endmodule

>>> tb/tb.sv
// Self-checking testbench for gradient_nms_edge_thinner:
// a frame of planted pixels, then random frames.
// Depends on gnms_pkg and the DUT; a line-store predictor in this file supplies every expected beat.
`timescale 1ns / 1ps

module tb;
  import gnms_pkg::*;

  // Index that no register answers to; writes there must change nothing
  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int N_PLANTS   = 21;
  // Pixel budget after the directed frame, fixed extremes included
  localparam int RAND_ITEMS = 1300;
  localparam int DRAIN_CYC  = 8;

  typedef struct packed {
    logic edge_res;
    logic row_end;
    logic frame_end;
  } nms_out_t;

  // Planted pixel: position, gradients, edge bit if obvious (-1 leaves it to the predictor)
  typedef struct {
    int row;
    int col;
    int gx;
    int gy;
    int want;
  } plant_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [MAG_W-1:0]   grad_x_abs;
  logic [MAG_W-1:0]   grad_y_abs;
  logic               frame_start;
  logic               out_valid;
  logic               out_ready;
  logic               edge_res;
  logic               row_end;
  logic               frame_end;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [IDX_W-1:0]   cfg_index;
  logic [CFG_W_W-1:0] cfg_data;

  // Predictor state: registers as written, line stores, counters
  int               cfg_width  = WIDTH_RST;
  int               cfg_height = HEIGHT_RST;
  int               cfg_thresh = THRESH_RST;
  bit [MAG_W-1:0]   up_mag  [MAX_WIDTH];
  bit [MAG_W-1:0]   ctr_mag [MAX_WIDTH];
  dir_t             ctr_dir [MAX_WIDTH];
  int               row_cnt, col_cnt, run_cnt;
  int               prev_up, prev_ctr;

  nms_out_t         pending_edges [$];
  bit               typed_edge [int];
  bit               no_idle = 1'b0;
  int               err_cnt, n_pixels, n_results, n_edges, n_settings;

  // Directed frame, 64 x 4 with threshold 100; everything else is zero
  plant_t plants [N_PLANTS] = '{
    '{0,  5, 255, 255,  0},   // top row never an edge
    '{0, 63, 255, 255,  0},
    '{1,  0, 255,   0,  0},   // left border column
    '{1,  5, 255,   0,  1},   // run starter far from the right edge survives
    '{1,  7, 200,   0,  1},   // inside the pass window of the run
    '{1,  9, 255,   0,  0},   // first cleared pixel of the run
    '{1, 56, 255,   0,  1},   // too close to the right edge to start a run
    '{2, 10,   0, 200,  0},   // zero gx: no direction
    '{2, 20, 255, 255,  0},   // starter whose run would pass the right edge
    '{2, 40, 255,   0,  0},   // still inside that run
    '{3, 30,  10, 255,  1},   // vertical, lower neighbour is the padding row
    '{3, 40,  25,  25,  0},   // magnitude equals threshold
    '{3, 45,  26,  25,  1},
    '{3, 50, 100,   0,  1},   // equal neighbours both kept
    '{3, 51, 100,   0,  1},
    '{3, 54, 100, 241, -1},   // just below the upper slope
    '{3, 56, 100, 242, -1},   // just above it
    '{3, 58, 255, 105, -1},   // just below the lower slope
    '{3, 60, 255, 106, -1},   // just above it
    '{3, 63, 255, 255,  1},   // right border, outside neighbour is zero
    '{4, 10, 255, 255, -1}    // padding row content is ignored
  };

  gradient_nms_edge_thinner u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .grad_x_abs  (grad_x_abs),
    .grad_y_abs  (grad_y_abs),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .edge_res    (edge_res),
    .row_end     (row_end),
    .frame_end   (frame_end),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int clamp_range(input int v, input int lo, input int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // One pixel through the thinner: returns the edge beat it releases, if any
  function automatic void thin_predict(input logic [MAG_W-1:0] gx, input logic [MAG_W-1:0] gy,
                                       input logic fs, output bit has, output nms_out_t res,
                                       output int oi, output int oj);
    int   w, h, m, q, c, cl, cr, ul, uc, ur, a, b;
    dir_t dir, d;
    bit   edge_bit;
    w = clamp_range(cfg_width, WIDTH_MIN, MAX_WIDTH);
    h = clamp_range(cfg_height, HEIGHT_MIN, HEIGHT_MAX);
    has = 1'b0;
    res = '0;
    oi = 0;
    oj = 0;
    if (fs) begin
      row_cnt = 0;
      col_cnt = 0;
    end
    if (col_cnt >= w) begin
      col_cnt = 0;
      row_cnt++;
    end
    if (row_cnt > h) row_cnt = 0;

    // magnitude and direction of the arriving pixel
    m = 0;
    dir = DIR_NONE;
    if (row_cnt < h) begin
      m = 2 * int'(gx) + 2 * int'(gy);
      if (m > 255) m = 255;
      if (gx != 0) begin
        q = (int'(gy) << 10) / int'(gx);
        if (q < SLOPE_LO) dir = DIR_HORZ;
        else if (q < SLOPE_HI) dir = DIR_DIAG;
        else dir = DIR_VERT;
      end
    end

    // decision for the pixel one row up
    if (row_cnt >= 1) begin
      oi = row_cnt - 1;
      oj = col_cnt;
      c  = int'(ctr_mag[oj]);
      d  = ctr_dir[oj];
      cl = (oj != 0) ? prev_ctr : 0;
      cr = (oj + 1 < w) ? int'(ctr_mag[oj + 1]) : 0;
      ul = (oj != 0) ? prev_up : 0;
      uc = int'(up_mag[oj]);
      ur = (oj + 1 < w) ? int'(up_mag[oj + 1]) : 0;
      edge_bit = 1'b0;
      if (oi != 0 && oj != 0 && d != DIR_NONE && c > MAG_FLOOR && c > cfg_thresh) begin
        case (d)
          DIR_HORZ: begin
            a = cl;
            b = cr;
          end
          DIR_DIAG: begin
            a = ur;
            b = ul;
          end
          default: begin
            a = uc;
            b = m;
          end
        endcase
        edge_bit = (c >= a && c >= b);
      end

      // run suppression along the row
      if (oj == 0) run_cnt = 0;
      if (oi >= 1 && oi <= h - 2) begin
        if (run_cnt != 0) begin
          if (RUN_LEN + 1 - run_cnt >= RUN_PASS) edge_bit = 1'b0;
          run_cnt--;
        end else if (edge_bit && oj >= 1 && oj + RUN_MARGIN < w) begin
          if (oj + RUN_LEN >= w) edge_bit = 1'b0;
          run_cnt = RUN_LEN;
        end
      end
      res.edge_res  = edge_bit;
      res.row_end   = (oj == w - 1);
      res.frame_end = (row_cnt == h && oj == w - 1);
      has = 1'b1;
    end

    // shift the line stores
    prev_up  = int'(up_mag[col_cnt]);
    prev_ctr = int'(ctr_mag[col_cnt]);
    up_mag[col_cnt]  = ctr_mag[col_cnt];
    ctr_mag[col_cnt] = m[MAG_W-1:0];
    ctr_dir[col_cnt] = dir;
    col_cnt++;
  endfunction

  task automatic report_mismatch(input string what, input logic want, input logic got);
    $display("mismatch %s: expected %b got %b (result %0d, t=%0t)", what, want, got,
             n_results, $realtime);
    err_cnt++;
  endtask

  // Called at a falling edge; returns at the falling edge after the beat
  task automatic push_pixel(input logic [MAG_W-1:0] gx, input logic [MAG_W-1:0] gy,
                            input logic fs);
    int       gap, oi, oj;
    bit       has;
    nms_out_t res;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    grad_x_abs  <= gx;
    grad_y_abs  <= gy;
    frame_start <= fs;
    do @(posedge clk); while (!in_ready);
    thin_predict(gx, gy, fs, has, res, oi, oj);
    if (has) begin
      if (typed_edge.exists(oi * MAX_WIDTH + oj)) res.edge_res = typed_edge[oi * MAX_WIDTH + oj];
      pending_edges = {pending_edges, res};
    end
    n_pixels++;
    @(negedge clk);
  endtask

  // Register writes; the block is idle whenever this runs
  task automatic set_config(input logic [CFG_W_W-1:0] w_data, input logic [CFG_W_W-1:0] h_data,
                            input logic [CFG_W_W-1:0] thr_data, input bit spare);
    logic [IDX_W-1:0]   idx [4];
    logic [CFG_W_W-1:0] val [4];
    int                 n;
    idx[0] = REG_WIDTH;
    idx[1] = REG_HEIGHT;
    idx[2] = REG_THRESH;
    idx[3] = REG_SPARE;
    val[0] = w_data;
    val[1] = h_data;
    val[2] = thr_data;
    val[3] = CFG_W_W'($urandom_range(0, 2047));
    n = spare ? 4 : 3;
    for (int k = 0; k < n; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      do @(posedge clk); while (!cfg_ready);
      case (idx[k])
        REG_WIDTH:  cfg_width  = int'(val[k]);
        REG_HEIGHT: cfg_height = int'(val[k][ROW_W-1:0]);
        REG_THRESH: cfg_thresh = int'(val[k][THR_W-1:0]);
        default: ;
      endcase
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // Sender holds off until every expected beat is out, then lets the pipe settle
  task automatic wait_idle();
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    @(negedge clk);
  endtask

  // One register setting and its frames; rows_cap > 0 cuts every frame short
  task automatic run_phase(input logic [CFG_W_W-1:0] w_data, input logic [CFG_W_W-1:0] h_data,
                           input logic [CFG_W_W-1:0] thr_data, input int frames,
                           input int rows_cap, input bit noisy, input bit quiet, input bit spare);
    int               w, h;
    logic [MAG_W-1:0] gx, gy;
    logic             fs;
    wait_idle();
    set_config(w_data, h_data, thr_data, spare);
    no_idle = quiet;
    w = clamp_range(int'(w_data), WIDTH_MIN, MAX_WIDTH);
    h = clamp_range(int'(h_data[ROW_W-1:0]), HEIGHT_MIN, HEIGHT_MAX);
    for (int f = 0; f < frames; f++) begin
      for (int r = 0; r <= h && (rows_cap == 0 || r <= rows_cap); r++) begin
        for (int c = 0; c < w; c++) begin
          fs = (f == 0 && r == 0 && c == 0) || (noisy && $urandom_range(0, 299) == 0);
          if (noisy) begin
            gx = MAG_W'($urandom_range(0, 255));
            gy = MAG_W'($urandom_range(0, 255));
          end else begin
            // mostly flat background with scattered strong and weak gradients
            case ($urandom_range(0, 9))
              0, 1, 2: begin
                gx = '0;
                gy = '0;
              end
              3: begin
                gx = '0;
                gy = MAG_W'($urandom_range(0, 255));
              end
              4, 5: begin
                gx = MAG_W'($urandom_range(0, 255));
                gy = MAG_W'($urandom_range(0, 255));
              end
              6: begin
                gx = MAG_W'($urandom_range(0, 40));
                gy = MAG_W'($urandom_range(0, 40));
              end
              7: begin
                gx = 8'hFF;
                gy = MAG_W'($urandom_range(0, 255));
              end
              8: begin
                gx = MAG_W'($urandom_range(1, 255));
                gy = 8'hFF;
              end
              default: begin
                gx = MAG_W'($urandom_range(100, 255));
                gy = MAG_W'($urandom_range(100, 255));
              end
            endcase
          end
          push_pixel(gx, gy, fs);
        end
      end
    end
    in_valid <= 1'b0;
    no_idle = 1'b0;
  endtask

  // Result side: random stalls, one draw per beat
  initial begin
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    nms_out_t want;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (pending_edges.size() == 0) begin
        report_mismatch("unexpected result beat", 1'b0, 1'b1);
      end else begin
        want = pending_edges.pop_front();
        if (edge_res !== want.edge_res) report_mismatch("edge_res", want.edge_res, edge_res);
        if (row_end !== want.row_end) report_mismatch("row_end", want.row_end, row_end);
        if (frame_end !== want.frame_end) report_mismatch("frame_end", want.frame_end, frame_end);
        if (want.edge_res) n_edges++;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d results outstanding", pending_edges.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [MAG_W-1:0] gx, gy;
    int               rand_base;
    rst         = 1'b1;
    in_valid    = 1'b0;
    grad_x_abs  = '0;
    grad_y_abs  = '0;
    frame_start = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_WIDTH;
    cfg_data    = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // directed frame from the plant table
    set_config(11'd64, 11'd4, 11'd100, 1'b0);
    for (int k = 0; k < N_PLANTS; k++)
      if (plants[k].want >= 0) typed_edge[plants[k].row * MAX_WIDTH + plants[k].col] = plants[k].want[0];
    for (int r = 0; r <= 4; r++) begin
      for (int c = 0; c < 64; c++) begin
        gx = '0;
        gy = '0;
        for (int k = 0; k < N_PLANTS; k++) begin
          if (plants[k].row == r && plants[k].col == c) begin
            gx = MAG_W'(plants[k].gx);
            gy = MAG_W'(plants[k].gy);
          end
        end
        push_pixel(gx, gy, r == 0 && c == 0);
      end
    end
    in_valid <= 1'b0;
    wait_idle();
    typed_edge.delete();

    // fixed extremes: narrowest and shortest with zero threshold, then tallest cut short
    rand_base = n_pixels;
    run_phase(11'd0, 11'd0, 11'd0, 2, 0, 1'b0, 1'b0, 1'b1);
    run_phase(11'd64, 11'd1023, 11'd255, 1, 5, 1'b0, 1'b1, 1'b0);

    // random settings, small frames
    while (n_pixels - rand_base < RAND_ITEMS) begin
      run_phase(CFG_W_W'($urandom_range(0, 1) ? $urandom_range(0, 63) :
                         $urandom_range(64, 130)),
                CFG_W_W'($urandom_range(0, 6)),
                CFG_W_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) :
                         ($urandom_range(0, 2) == 0) ? THRESH_RST : $urandom_range(0, 255)),
                $urandom_range(1, 2),
                ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0,
                $urandom_range(0, 3) == 0,
                $urandom_range(0, 3) == 0,
                $urandom_range(0, 5) == 0);
    end
    wait_idle();

    $display("Summary: %0d pixels under %0d register settings, %0d result beats checked",
             n_pixels, n_settings, n_results);
    $display("Summary: %0d thinned edge pixels seen, %0d mismatches", n_edges, err_cnt);
    if (err_cnt == 0 && pending_edges.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
